// ----- design/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and codes shared by the delta list timer queue and its slot memory.
// ----------------------------------------------------------------------------
package dltq_pkg;

    // Default number of timer slots
    localparam int TIMER_SLOTS_DEF = 16;
    // Most expiries reported by one tick
    localparam int MAX_RESULTS = 16;

    // Request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Status codes
    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_DUPLICATE = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_CANCELLED = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_EXPIRED   = 3'd5;
    localparam logic [2:0] STS_NONE      = 3'd6;

    // Input beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] session;
        logic [31:0] seq_num;
        logic [31:0] delay_ticks;
        logic [15:0] elapsed_ticks;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] exp_session;
        logic [31:0] exp_seq;
        logic        last;
    } t_out_item;

    // One slot of the delta list
    typedef struct packed {
        logic [15:0] session;
        logic [31:0] seq;
        logic [31:0] delta;
    } t_slot;

endpackage

// ----- design/dltq_ram.sv -----
// ----------------------------------------------------------------------------
// dltq_ram
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
    parameter int DEPTH = dltq_pkg::TIMER_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  dltq_pkg::t_slot     i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output dltq_pkg::t_slot     o_rdata
);

    dltq_pkg::t_slot r_mem [DEPTH];

    // Write, and read with registered read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/delta_list_timer_queue.sv -----
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Sorted delta list of timers held in one slot memory and walked by a
// sequencer: start, cancel and tick requests.
// ----------------------------------------------------------------------------
// Sequence: start and cancel scan all N live slots, then shift the tail
//   one slot per cycle; the result beat comes at the end of the scan. A
//   tick walks the due slots, then moves the survivors down one per cycle.
// Throughput: one request at a time; busy stays high for the whole walk, as
//   every step goes through the single memory read port.
// Reset: synchronous, clears the slot count and the sequencer; the memory
//   is not cleared. Results are strobes and cannot be stalled.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
    parameter int TIMER_SLOTS = dltq_pkg::TIMER_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dltq_pkg::t_in_item  i_req,
    output logic                busy,
    output logic                o_res_valid,
    output dltq_pkg::t_out_item o_res
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_WALK = 6'b000100,
        S_UP   = 6'b001000,
        S_PUT  = 6'b010000,
        S_DN   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [15:0]         r_ses, n_ses;
    logic [31:0]         r_seq, n_seq;
    logic [31:0]         r_delay, n_delay;
    logic [15:0]         r_over, n_over;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pv, n_pv;
    logic [CW-1:0]       r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [CW-1:0]       r_pos, n_pos;
    logic [31:0]         r_fdelta, n_fdelta;
    logic                r_placed, n_placed;
    logic [CW-1:0]       r_ins, n_ins;
    logic [CW-1:0]       r_due, n_due;
    logic                r_stop, n_stop;
    logic                r_hold_v, n_hold_v;
    logic [15:0]         r_hold_ses, n_hold_ses;
    logic [31:0]         r_hold_seq, n_hold_seq;
    logic                r_issue, n_issue;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_off, n_off;
    logic                r_o_valid, n_o_valid;
    dltq_pkg::t_out_item r_o_res, n_o_res;

    logic                w_issue;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    dltq_pkg::t_slot     w_wdata;
    dltq_pkg::t_slot     w_rdata;
    logic [CW-1:0]       w_ins_pos;
    logic [CW-1:0]       w_n;
    logic [32:0]         w_sum;
    logic                w_match;

    dltq_ram #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Helpers from the read data
    assign w_match   = (w_rdata.session == r_ses) && (w_rdata.seq == r_seq);
    assign w_sum     = {1'b0, w_rdata.delta} + {1'b0, r_fdelta};
    assign w_ins_pos = r_placed ? r_ins : r_count;
    assign w_n       = (32'(r_due) < 32'(dltq_pkg::MAX_RESULTS)) ? r_due
                                                              : CW'(dltq_pkg::MAX_RESULTS);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ses      = r_ses;
        n_seq      = r_seq;
        n_delay    = r_delay;
        n_over     = r_over;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pv       = 1'b0;
        n_pidx     = r_idx;
        n_found    = r_found;
        n_pos      = r_pos;
        n_fdelta   = r_fdelta;
        n_placed   = r_placed;
        n_ins      = r_ins;
        n_due      = r_due;
        n_stop     = r_stop;
        n_hold_v   = r_hold_v;
        n_hold_ses = r_hold_ses;
        n_hold_seq = r_hold_seq;
        n_issue    = r_issue;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_off      = r_off;
        n_o_valid  = 1'b0;
        n_o_res    = '0;
        w_issue    = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_pidx[AW-1:0];
        w_wdata    = w_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_req.req_type;
                    n_ses    = i_req.session;
                    n_seq    = i_req.seq_num;
                    n_delay  = i_req.delay_ticks;
                    n_over   = i_req.elapsed_ticks;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_placed = 1'b0;
                    n_due    = '0;
                    n_stop   = 1'b0;
                    n_hold_v = 1'b0;
                    if (i_req.req_type == dltq_pkg::REQ_START ||
                        i_req.req_type == dltq_pkg::REQ_CANCEL) begin
                        n_state = S_SCAN;
                    end else if (i_req.req_type == dltq_pkg::REQ_TICK) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_SCAN: begin
                // Read every live slot, one per cycle
                w_issue = (r_idx < r_count);
                n_pv    = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pv) begin
                    if (w_match && !r_found) begin
                        n_found  = 1'b1;
                        n_pos    = r_pidx;
                        n_fdelta = w_rdata.delta;
                    end
                    if (r_op == dltq_pkg::REQ_START && !r_placed) begin
                        if (r_delay < w_rdata.delta) begin
                            n_placed = 1'b1;
                            n_ins    = r_pidx;
                        end else begin
                            n_delay = r_delay - w_rdata.delta;
                        end
                    end
                end
                if (!w_issue && !r_pv) begin
                    n_o_valid    = 1'b1;
                    n_o_res.last = 1'b1;
                    n_state      = S_IDLE;
                    if (r_op == dltq_pkg::REQ_START) begin
                        n_ins = w_ins_pos;
                        if (r_found) begin
                            n_o_res.status = dltq_pkg::STS_DUPLICATE;
                        end else if (r_count == SLOTS_C) begin
                            n_o_res.status = dltq_pkg::STS_FULL;
                        end else begin
                            n_o_res.status = dltq_pkg::STS_INSERTED;
                            if (w_ins_pos < r_count) begin
                                n_state = S_UP;
                                n_idx   = r_count - 1'b1;
                                n_lo    = w_ins_pos;
                                n_issue = 1'b1;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                    end else begin
                        if (!r_found) begin
                            n_o_res.status = dltq_pkg::STS_NOT_FOUND;
                        end else begin
                            n_o_res.status = dltq_pkg::STS_CANCELLED;
                            if (CW'(r_pos + 1'b1) < r_count) begin
                                n_state = S_DN;
                                n_idx   = r_pos + 1'b1;
                                n_hi    = r_count - 1'b1;
                                n_off   = CW'(1);
                                n_issue = 1'b1;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                // Move the tail up by one, from the end towards the gap
                w_issue = r_issue;
                n_pv    = w_issue;
                if (w_issue) begin
                    if (r_idx == r_lo) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_pidx + 1'b1);
                    if (r_pidx == r_ins) begin
                        w_wdata.delta = w_rdata.delta - r_delay;
                    end
                end
                if (!r_issue && !r_pv) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                w_we          = 1'b1;
                w_waddr       = r_ins[AW-1:0];
                w_wdata.session = r_ses;
                w_wdata.seq   = r_seq;
                w_wdata.delta = r_delay;
                n_count       = r_count + 1'b1;
                n_state       = S_IDLE;
            end
            S_DN: begin
                // Move the tail down by r_off slots
                w_issue = r_issue;
                n_pv    = w_issue;
                if (w_issue) begin
                    if (r_idx == r_hi) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_pidx - r_off);
                    if (r_op == dltq_pkg::REQ_CANCEL && r_pidx == CW'(r_pos + 1'b1)) begin
                        w_wdata.delta = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                    end
                end
                if (!r_issue && !r_pv) begin
                    n_count = r_count - r_off;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                // Carry elapsed ticks down the list, reporting due slots
                w_issue = !r_stop && (r_idx < r_count);
                n_pv    = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pv && !r_stop) begin
                    w_we = 1'b1;
                    if (w_rdata.delta > {16'd0, r_over}) begin
                        w_wdata.delta = w_rdata.delta - {16'd0, r_over};
                        n_stop        = 1'b1;
                    end else begin
                        w_wdata.delta = '0;
                        n_over        = r_over - w_rdata.delta[15:0];
                        n_due         = r_due + 1'b1;
                        if (32'(r_due) < 32'(dltq_pkg::MAX_RESULTS)) begin
                            if (r_hold_v) begin
                                n_o_valid           = 1'b1;
                                n_o_res.status      = dltq_pkg::STS_EXPIRED;
                                n_o_res.exp_session = r_hold_ses;
                                n_o_res.exp_seq     = r_hold_seq;
                            end
                            n_hold_v   = 1'b1;
                            n_hold_ses = w_rdata.session;
                            n_hold_seq = w_rdata.seq;
                        end
                    end
                end
                if (!w_issue && !r_pv) begin
                    n_o_valid    = 1'b1;
                    n_o_res.last = 1'b1;
                    n_state      = S_IDLE;
                    if (r_hold_v) begin
                        n_o_res.status      = dltq_pkg::STS_EXPIRED;
                        n_o_res.exp_session = r_hold_ses;
                        n_o_res.exp_seq     = r_hold_seq;
                        if (w_n < r_count) begin
                            n_state = S_DN;
                            n_idx   = w_n;
                            n_hi    = r_count - 1'b1;
                            n_off   = w_n;
                            n_issue = 1'b1;
                        end else begin
                            n_count = r_count - w_n;
                        end
                    end else begin
                        n_o_res.status = dltq_pkg::STS_NONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_o_valid <= n_o_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ses      <= n_ses;
        r_seq      <= n_seq;
        r_delay    <= n_delay;
        r_over     <= n_over;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_fdelta   <= n_fdelta;
        r_placed   <= n_placed;
        r_ins      <= n_ins;
        r_due      <= n_due;
        r_stop     <= n_stop;
        r_hold_v   <= n_hold_v;
        r_hold_ses <= n_hold_ses;
        r_hold_seq <= n_hold_seq;
        r_issue    <= n_issue;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_off      <= n_off;
        r_o_res    <= n_o_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("slot count above capacity");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == dltq_pkg::STS_NONE) |-> o_res.last)
        else $error("none-expired beat without last");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !start) |=> $stable(r_count))
        else $error("slot count moved while idle");

endmodule

// ----- dv/delta_list_timer_queue_test.sv -----
// ----------------------------------------------------------------------------
// delta_list_timer_queue_test
// Drives start, cancel and tick requests into the timer queue, keeps its own
// sorted delta list to work out every status and expiry beat, and compares
// each result beat in order against the expected beats.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_test;

    localparam int SLOTS     = dltq_pkg::TIMER_SLOTS_DEF;
    localparam int CYC_LIMIT = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    dltq_pkg::t_in_item  i_req = '0;
    logic                busy;
    logic                o_res_valid;
    dltq_pkg::t_out_item o_res;

    delta_list_timer_queue #(.TIMER_SLOTS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_res_valid(o_res_valid), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    // Shadow delta list
    logic [15:0] q_ses [SLOTS];
    logic [31:0] q_seq [SLOTS];
    logic [31:0] q_dly [SLOTS];
    int          q_cnt = 0;

    dltq_pkg::t_in_item  req_q [$];
    dltq_pkg::t_out_item exp_beats [$];
    int                  errors = 0;
    int                  gap_pct = 0;
    int                  cycles = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic dltq_pkg::t_out_item beat(input logic [2:0] s, input logic [15:0] ses,
                                                 input logic [31:0] seq, input logic l);
        dltq_pkg::t_out_item b;
        b.status = s; b.exp_session = ses; b.exp_seq = seq; b.last = l;
        return b;
    endfunction

    function automatic int find_timer(input logic [15:0] ses, input logic [31:0] seq);
        for (int i = 0; i < q_cnt; i++)
            if (q_ses[i] == ses && q_seq[i] == seq) return i;
        return q_cnt;
    endfunction

    function automatic void drop_slot(input int p);
        for (int i = p; i + 1 < q_cnt; i++) begin
            q_ses[i] = q_ses[i+1]; q_seq[i] = q_seq[i+1]; q_dly[i] = q_dly[i+1];
        end
        q_cnt--;
    endfunction

    // Work out the result beats of one accepted request
    function automatic void predict_timers(input dltq_pkg::t_in_item r);
        int p;
        int due;
        logic [31:0] d, over;
        logic [32:0] sum;
        case (r.req_type)
            dltq_pkg::REQ_START: begin
                if (find_timer(r.session, r.seq_num) < q_cnt)
                    exp_beats.push_back(beat(dltq_pkg::STS_DUPLICATE, '0, '0, 1'b1));
                else if (q_cnt >= SLOTS)
                    exp_beats.push_back(beat(dltq_pkg::STS_FULL, '0, '0, 1'b1));
                else begin
                    d = r.delay_ticks;
                    for (p = 0; p < q_cnt; p++) begin
                        if (d < q_dly[p]) break;
                        d -= q_dly[p];
                    end
                    for (int i = q_cnt; i > p; i--) begin
                        q_ses[i] = q_ses[i-1]; q_seq[i] = q_seq[i-1]; q_dly[i] = q_dly[i-1];
                    end
                    q_ses[p] = r.session; q_seq[p] = r.seq_num; q_dly[p] = d;
                    q_cnt++;
                    if (p + 1 < q_cnt) q_dly[p+1] -= d;
                    exp_beats.push_back(beat(dltq_pkg::STS_INSERTED, '0, '0, 1'b1));
                end
            end
            dltq_pkg::REQ_CANCEL: begin
                p = find_timer(r.session, r.seq_num);
                if (p >= q_cnt)
                    exp_beats.push_back(beat(dltq_pkg::STS_NOT_FOUND, '0, '0, 1'b1));
                else begin
                    if (p + 1 < q_cnt) begin
                        sum = {1'b0, q_dly[p+1]} + {1'b0, q_dly[p]};
                        q_dly[p+1] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                    drop_slot(p);
                    exp_beats.push_back(beat(dltq_pkg::STS_CANCELLED, '0, '0, 1'b1));
                end
            end
            dltq_pkg::REQ_TICK: begin
                over = {16'd0, r.elapsed_ticks};
                due = 0;
                for (int i = 0; i < q_cnt; i++) begin
                    if (q_dly[i] > over) begin
                        q_dly[i] -= over;
                        break;
                    end
                    over -= q_dly[i];
                    q_dly[i] = 0;
                    due++;
                end
                if (due > dltq_pkg::MAX_RESULTS) due = dltq_pkg::MAX_RESULTS;
                if (due == 0) exp_beats.push_back(beat(dltq_pkg::STS_NONE, '0, '0, 1'b1));
                while (due > 0) begin
                    due--;
                    exp_beats.push_back(beat(dltq_pkg::STS_EXPIRED, q_ses[0], q_seq[0],
                                             due == 0));
                    drop_slot(0);
                end
            end
            default: ;
        endcase
    endfunction

    // Driver: offer the next queued beat, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            predict_timers(i_req);
            void'(req_q.pop_front());
            if (req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                i_req <= req_q[0];
            end else begin
                start <= 1'b0;
                i_req <= '0;
            end
        end else if (!start && req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
            start <= 1'b1;
            i_req <= req_q[0];
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        dltq_pkg::t_out_item e;
        if (i_rst_n && o_res_valid) begin
            if (exp_beats.size() == 0) begin
                report($sformatf("unexpected beat %h", o_res));
            end else begin
                e = exp_beats.pop_front();
                if (o_res.status !== e.status)
                    report($sformatf("status %0d, want %0d", o_res.status, e.status));
                if (o_res.exp_session !== e.exp_session)
                    report($sformatf("session %h, want %h", o_res.exp_session, e.exp_session));
                if (o_res.exp_seq !== e.exp_seq)
                    report($sformatf("seq %h, want %h", o_res.exp_seq, e.exp_seq));
                if (o_res.last !== e.last)
                    report($sformatf("last %b, want %b", o_res.last, e.last));
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic dltq_pkg::t_in_item mk(input logic [1:0] t, input logic [15:0] ses,
                                              input logic [31:0] seq, input logic [31:0] dly,
                                              input logic [15:0] el);
        dltq_pkg::t_in_item r;
        r.req_type = t; r.session = ses; r.seq_num = seq;
        r.delay_ticks = dly; r.elapsed_ticks = el;
        return r;
    endfunction

    // Random request: mostly valid codes, some unused, on a small pool of ids so that
    // duplicates, cancels of live timers and expiries all happen
    function automatic dltq_pkg::t_in_item rand_req();
        dltq_pkg::t_in_item r;
        int k;
        r = '0;
        r.session = 16'($urandom);
        r.seq_num = $urandom;
        r.elapsed_ticks = 16'($urandom);
        k = $urandom_range(99);
        if (k < 50) r.req_type = dltq_pkg::REQ_START;
        else if (k < 72) r.req_type = dltq_pkg::REQ_CANCEL;
        else if (k < 97) r.req_type = dltq_pkg::REQ_TICK;
        else r.req_type = 2'd3;
        if ($urandom_range(3) != 0) begin
            r.session = 16'($urandom_range(3));
            r.seq_num = $urandom_range(7);
        end
        case ($urandom_range(3))
            0: r.delay_ticks = $urandom_range(40);
            1: r.delay_ticks = $urandom_range(2000);
            2: r.delay_ticks = $urandom;
            default: r.delay_ticks = 32'hFFFF_FFF0 + $urandom_range(15);
        endcase
        if ($urandom_range(3) != 0) r.elapsed_ticks = 16'($urandom_range(60));
        return r;
    endfunction

    task automatic drain();
        while (req_q.size() != 0 || start || busy || exp_beats.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero delay, equal delays, duplicate, full, overflow carry
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 0));
        req_q.push_back(mk(dltq_pkg::REQ_CANCEL, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 16'hFFFF, 32'hFFFF_FFFF, 5, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 0, 0, 0, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 1, 0, 10, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 1, 1, 10, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 2, 0, 32'hFFFF_FFFE, 0));
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 0));
        req_q.push_back(mk(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        req_q.push_back(mk(dltq_pkg::REQ_CANCEL, 2, 0, 0, 0));
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 10));
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 16'hFFFF));
        for (int i = 0; i < 17; i++)
            req_q.push_back(mk(dltq_pkg::REQ_START, 16'h100, i, 3, 0));
        req_q.push_back(mk(dltq_pkg::REQ_START, 16'h100, 0, 3, 0));
        drain();
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 3));
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 0));
        req_q.push_back(mk(dltq_pkg::REQ_TICK, 0, 0, 0, 16'hFFFF));

        // Random phases with varying sender gaps
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = (ph == 0) ? 0 : (ph == 1) ? 46 : (ph == 2) ? 31 : 0;
            for (int n = 0; n < 17; n++) req_q.push_back(rand_req());
            drain();
        end

        repeat (80) @(posedge i_clk);
        if (errors == 0 && exp_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- delta_list_timer_queue.f -----
design/dltq_pkg.sv
design/dltq_ram.sv
design/delta_list_timer_queue.sv
dv/delta_list_timer_queue_test.sv
